// File: hdl/ldac_pkg.sv
// Shared types, constants and command codes of the discriminant classifier.
package ldac_pkg;

	localparam int MAX_CLASSES  = 8;
	localparam int MAX_FEATURES = 16;
	localparam int CLS_W        = $clog2(MAX_CLASSES);
	localparam int FEAT_W       = $clog2(MAX_FEATURES);
	localparam int QDEPTH       = 4;
	localparam int QPTR_W       = $clog2(QDEPTH);

	// Configuration register indexes
	localparam logic [1:0] CFG_NUM_CLASSES  = 2'd0;
	localparam logic [1:0] CFG_NUM_FEATURES = 2'd1;

	// Command codes on the input channel
	localparam logic [1:0] CMD_CENTER = 2'd0;
	localparam logic [1:0] CMD_COV    = 2'd1;
	localparam logic [1:0] CMD_BIAS   = 2'd2;
	localparam logic [1:0] CMD_SAMPLE = 2'd3;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [3:0]         row;
		logic [3:0]         col;
		logic signed [15:0] value;
		logic [2:0]         true_label;
		logic               last;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         best_class;
		logic signed [63:0] best_score;
		logic               mismatch;
	} out_item_t;

	typedef enum logic [1:0] {
		OP_CENTER,
		OP_COV,
		OP_BIAS,
		OP_SAMPLE
	} op_t;

	// Decoded item passed from front to back
	typedef struct packed {
		op_t                op;
		logic               hit;
		logic [3:0]         row;
		logic [3:0]         col;
		logic signed [15:0] value;
		logic [2:0]         label;
		logic               last;
	} q_item_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_DIFF,
		B_DWAIT,
		B_ROW,
		B_DRAIN,
		B_FIN1,
		B_FIN2,
		B_FIN3,
		B_SCORE,
		B_CMP,
		B_OUT
	} bstate_t;

endpackage

// File: hdl/ldac_ram.sv
// Generic single write port RAM with registered read.
module ldac_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: hdl/ldac_front.sv
// Front end: accepts items, decodes the command and queues them for the back end.
module ldac_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  ldac_pkg::in_item_t in_item,
	output logic              q_valid,
	input  logic              q_stall,
	output ldac_pkg::q_item_t q_item
);
	import ldac_pkg::*;

	q_item_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QPTR_W:0]     count_q;
	q_item_t             dec;
	logic                push;
	logic                pop;

	// Decode command and range check
	always_comb begin
		dec.row   = in_item.row;
		dec.col   = in_item.col;
		dec.value = in_item.value;
		dec.label = in_item.true_label;
		dec.last  = 1'b0;
		case (in_item.cmd)
			CMD_CENTER: begin
				dec.op  = OP_CENTER;
				dec.hit = (32'(in_item.row) < MAX_CLASSES) && (32'(in_item.col) < MAX_FEATURES);
			end
			CMD_COV: begin
				dec.op  = OP_COV;
				dec.hit = (32'(in_item.row) < MAX_FEATURES) && (32'(in_item.col) < MAX_FEATURES);
			end
			CMD_BIAS: begin
				dec.op  = OP_BIAS;
				dec.hit = (32'(in_item.row) < MAX_CLASSES);
			end
			default: begin
				dec.op   = OP_SAMPLE;
				dec.hit  = (32'(in_item.col) < MAX_FEATURES);
				dec.last = in_item.last;
			end
		endcase
	end

	assign in_stall = (count_q == (QPTR_W+1)'(QDEPTH));
	assign push     = in_valid && !in_stall;
	assign q_valid  = (count_q != '0);
	assign pop      = q_valid && !q_stall;
	assign q_item   = mem_q[rd_ptr_q];

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= dec;
		end
	end

	// Advance queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: hdl/ldac_back.sv
// Back end: applies table loads and scores every class with one shared MAC.
module ldac_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [3:0]         num_classes,
	input  logic [4:0]         num_features,
	input  logic               q_valid,
	output logic               q_stall,
	input  ldac_pkg::q_item_t  q_item,
	output logic               out_valid,
	input  logic               out_stall,
	output ldac_pkg::out_item_t out_item
);
	import ldac_pkg::*;

	localparam int CA_W = CLS_W + FEAT_W;
	localparam int SA_W = 2 * FEAT_W;

	bstate_t                  state_q, state_nx;
	logic [CLS_W-1:0]         c_q;
	logic [FEAT_W-1:0]        j_q, k_q, k_s1, d_addr;
	logic                     v_s1, v_s2, dv_s1;
	logic signed [16:0]       d_q [MAX_FEATURES];
	logic signed [15:0]       sample_q [MAX_FEATURES];
	logic signed [15:0]       bias_q [MAX_CLASSES];
	logic [2:0]               label_q;
	logic signed [16:0]       dk_s1, d_rd;
	logic signed [32:0]       prod_s2;
	logic signed [36:0]       t_q;
	logic signed [35:0]       prod_hi_q;
	logic signed [34:0]       prod_lo_q;
	logic [63:0]              quad_q, score_q, best_q;
	logic [CLS_W-1:0]         best_cls_q;
	logic                     out_valid_q;
	out_item_t                out_q;
	logic [3:0]               nc_eff;
	logic [4:0]               nf_eff;
	logic                     last_k, last_j, last_c, pop, out_free;
	logic                     c_we, s_we;
	logic [CA_W-1:0]          c_waddr, c_raddr;
	logic [SA_W-1:0]          s_waddr, s_raddr;
	logic [15:0]              c_rd, s_rd;

	// Clamp counts to the supported range
	always_comb begin
		if (num_classes == 4'd0) begin
			nc_eff = 4'd1;
		end else if (32'(num_classes) > MAX_CLASSES) begin
			nc_eff = 4'(MAX_CLASSES);
		end else begin
			nc_eff = num_classes;
		end
		if (num_features == 5'd0) begin
			nf_eff = 5'd1;
		end else if (32'(num_features) > MAX_FEATURES) begin
			nf_eff = 5'(MAX_FEATURES);
		end else begin
			nf_eff = num_features;
		end
	end

	assign last_k   = (5'(k_q) == nf_eff - 5'd1);
	assign last_j   = (5'(j_q) == nf_eff - 5'd1);
	assign last_c   = (4'(c_q) == nc_eff - 4'd1);
	assign q_stall  = (state_q != B_IDLE);
	assign pop      = q_valid && (state_q == B_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	// Table memories
	assign c_we    = pop && (q_item.op == OP_CENTER) && q_item.hit;
	assign c_waddr = {q_item.row[CLS_W-1:0], q_item.col[FEAT_W-1:0]};
	assign c_raddr = {c_q, k_q};
	assign s_we    = pop && (q_item.op == OP_COV) && q_item.hit;
	assign s_waddr = {q_item.row[FEAT_W-1:0], q_item.col[FEAT_W-1:0]};
	assign s_raddr = {j_q, k_q};

	ldac_ram #(.WIDTH(16), .DEPTH(MAX_CLASSES * MAX_FEATURES)) u_center (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_waddr),
		.wdata (q_item.value),
		.raddr (c_raddr),
		.rdata (c_rd)
	);

	ldac_ram #(.WIDTH(16), .DEPTH(MAX_FEATURES * MAX_FEATURES)) u_cov (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (q_item.value),
		.raddr (s_raddr),
		.rdata (s_rd)
	);

	assign d_addr = (state_q == B_FIN1 || state_q == B_FIN2) ? j_q : k_q;
	assign d_rd   = d_q[d_addr];

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			B_IDLE: begin
				if (pop && q_item.op == OP_SAMPLE && q_item.last) begin
					state_nx = B_DIFF;
				end
			end
			B_DIFF: begin
				if (last_k) begin
					state_nx = B_DWAIT;
				end
			end
			B_DWAIT: state_nx = B_ROW;
			B_ROW: begin
				if (last_k) begin
					state_nx = B_DRAIN;
				end
			end
			B_DRAIN: begin
				if (!v_s1 && !v_s2) begin
					state_nx = B_FIN1;
				end
			end
			B_FIN1: state_nx = B_FIN2;
			B_FIN2: state_nx = B_FIN3;
			B_FIN3: state_nx = last_j ? B_SCORE : B_ROW;
			B_SCORE: state_nx = B_CMP;
			B_CMP: state_nx = last_c ? B_OUT : B_DIFF;
			B_OUT: begin
				if (out_free) begin
					state_nx = B_IDLE;
				end
			end
			default: state_nx = B_IDLE;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Control counters and pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			dv_s1       <= 1'b0;
			label_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1  <= (state_q == B_ROW);
			v_s2  <= v_s1;
			dv_s1 <= (state_q == B_DIFF);
			if (pop && q_item.op == OP_SAMPLE) begin
				label_q <= q_item.label;
			end
			case (state_q)
				B_IDLE: begin
					c_q <= '0;
					j_q <= '0;
					k_q <= '0;
				end
				B_DIFF, B_ROW: begin
					k_q <= last_k ? '0 : k_q + 1'b1;
				end
				B_DWAIT: begin
					j_q <= '0;
					k_q <= '0;
				end
				B_FIN3: begin
					k_q <= '0;
					j_q <= j_q + 1'b1;
				end
				B_CMP: begin
					c_q <= c_q + 1'b1;
					k_q <= '0;
				end
				default: ;
			endcase
			if (state_q == B_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath: loads, differences, MAC and class compare
	always_ff @(posedge clk) begin
		if (pop && q_item.op == OP_BIAS && q_item.hit) begin
			bias_q[q_item.row[CLS_W-1:0]] <= q_item.value;
		end
		if (pop && q_item.op == OP_SAMPLE && q_item.hit) begin
			sample_q[q_item.col[FEAT_W-1:0]] <= q_item.value;
		end
		k_s1  <= k_q;
		dk_s1 <= d_rd;
		if (dv_s1) begin
			d_q[k_s1] <= 17'(sample_q[k_s1]) - 17'($signed(c_rd));
		end
		prod_s2 <= 33'($signed(s_rd)) * 33'(dk_s1);
		if (v_s2) begin
			t_q <= t_q + 37'(prod_s2);
		end
		case (state_q)
			B_DWAIT: begin
				t_q    <= '0;
				quad_q <= '0;
			end
			B_FIN1: begin
				prod_hi_q <= 36'(d_rd) * 36'($signed(t_q[36:18]));
			end
			B_FIN2: begin
				quad_q    <= quad_q + (64'(prod_hi_q) << 18);
				prod_lo_q <= 35'(d_rd) * $signed({17'd0, t_q[17:0]});
			end
			B_FIN3: begin
				quad_q <= quad_q + 64'(prod_lo_q);
				t_q    <= '0;
			end
			B_SCORE: begin
				score_q <= (64'(bias_q[c_q]) << 20) - quad_q;
			end
			B_CMP: begin
				if (c_q == '0 || $signed(score_q) > $signed(best_q)) begin
					best_q     <= score_q;
					best_cls_q <= c_q;
				end
			end
			B_OUT: begin
				if (out_free) begin
					out_q.best_class <= 3'(best_cls_q);
					out_q.best_score <= best_q;
					out_q.mismatch   <= (3'(best_cls_q) != label_q);
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

// File: hdl/lda_discriminant_classifier_top.sv
// Top level of the linear discriminant classifier.
// Items enter through a four-entry queue and are carried out one at a time by a single
// multiply-accumulate sequencer. Table loads and non-final sample features are applied
// as they are taken from the queue and do not hold the sequencer busy. Once the final
// feature of a sample is taken from the queue, the MAC walks every element of the
// inverse covariance matrix once per class, with a pipeline drain and a split 17x37
// product per row, after which the result register is loaded; it waits while an earlier
// result is still held.
// The queue keeps accepting items while a score is being worked out,
// and the result register lets the next sample start while a result waits to be taken.
module lda_discriminant_classifier_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  ldac_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output ldac_pkg::out_item_t out_item,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [4:0]          cfg_data
);
	import ldac_pkg::*;

	logic [3:0] num_classes_q;
	logic [4:0] num_features_q;
	logic       q_valid;
	logic       q_stall;
	q_item_t    q_item;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_classes_q  <= 4'd2;
			num_features_q <= 5'd16;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_NUM_CLASSES:  num_classes_q  <= cfg_data[3:0];
				CFG_NUM_FEATURES: num_features_q <= cfg_data;
				default: ;
			endcase
		end
	end

	ldac_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.q_valid  (q_valid),
		.q_stall  (q_stall),
		.q_item   (q_item)
	);

	ldac_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.num_classes  (num_classes_q),
		.num_features (num_features_q),
		.q_valid      (q_valid),
		.q_stall      (q_stall),
		.q_item       (q_item),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_item     (out_item)
	);

endmodule
